@@ hw/rtl/acpi_resource_template_parser_top_assert.svh @@
// assertion macros for the resource template parser
`ifndef ACPI_RESOURCE_TEMPLATE_PARSER_TOP_ASSERT_SVH
`define ACPI_RESOURCE_TEMPLATE_PARSER_TOP_ASSERT_SVH

// same-cycle implication
`define ARP_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("arp check failed");

// next-cycle implication
`define ARP_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("arp check failed");

`endif

@@ hw/rtl/arp_pkg.sv @@
// shared types, codes and helpers for the resource template parser
package arp_pkg;

  localparam int MAX_RECORDS_DEF = 32;

  typedef enum logic [2:0] {
    PH_TAG    = 3'd0,
    PH_LEN_LO = 3'd1,
    PH_LEN_HI = 3'd2,
    PH_BODY   = 3'd3,
    PH_DRAIN  = 3'd4
  } phase_t;

  localparam logic [3:0] KIND_NONE    = 4'd0;
  localparam logic [3:0] KIND_IRQ     = 4'd1;
  localparam logic [3:0] KIND_DMA     = 4'd2;
  localparam logic [3:0] KIND_IOPORT  = 4'd3;
  localparam logic [3:0] KIND_FIXEDIO = 4'd4;
  localparam logic [3:0] KIND_MEM32   = 4'd5;
  localparam logic [3:0] KIND_EXTIRQ  = 4'd6;
  localparam logic [3:0] KIND_WORD    = 4'd7;
  localparam logic [3:0] KIND_DWORD   = 4'd8;
  localparam logic [3:0] KIND_QWORD   = 4'd9;

  localparam logic [3:0] ST_IRQ     = 4'h4;
  localparam logic [3:0] ST_DMA     = 4'h5;
  localparam logic [3:0] ST_IOPORT  = 4'h8;
  localparam logic [3:0] ST_FIXEDIO = 4'h9;
  localparam logic [3:0] ST_END     = 4'hF;

  localparam logic [6:0] LT_MEM32    = 7'h05;
  localparam logic [6:0] LT_FIXMEM32 = 7'h06;
  localparam logic [6:0] LT_DWORD    = 7'h07;
  localparam logic [6:0] LT_WORD     = 7'h08;
  localparam logic [6:0] LT_EXTIRQ   = 7'h09;
  localparam logic [6:0] LT_QWORD    = 7'h0A;

  typedef struct packed {
    logic [63:0] base;
    logic [63:0] length;
    logic [63:0] gran;
    logic [7:0]  flags;
    logic [15:0] mask;
    logic [31:0] number;
    logic        attr;
    logic [7:0]  align;
    logic [7:0]  irq_count;
  } held_t;

  function automatic logic [63:0] lane(logic [63:0] acc, logic [15:0] idx,
                                       int start, int n, logic [7:0] b);
    logic [15:0] off;
    logic [63:0] r;
    off = idx - 16'(start);
    r = acc;
    if (idx >= 16'(start) && off < 16'(n))
      r = acc | ({56'd0, b} << {off[2:0], 3'b000});
    return r;
  endfunction

  function automatic logic [3:0] kind_of(logic [7:0] t, logic [15:0] len);
    logic [3:0] k;
    k = KIND_NONE;
    if (!t[7]) begin
      case (t[6:3])
        ST_IRQ:     if (len >= 16'd2) k = KIND_IRQ;
        ST_DMA:     if (len >= 16'd2) k = KIND_DMA;
        ST_IOPORT:  if (len >= 16'd7) k = KIND_IOPORT;
        ST_FIXEDIO: if (len >= 16'd3) k = KIND_FIXEDIO;
        default:    k = KIND_NONE;
      endcase
    end else begin
      case (t[6:0])
        LT_EXTIRQ:   if (len >= 16'd2)  k = KIND_EXTIRQ;
        LT_MEM32:    if (len >= 16'd17) k = KIND_MEM32;
        LT_FIXMEM32: if (len >= 16'd9)  k = KIND_MEM32;
        LT_DWORD:    if (len >= 16'd23) k = KIND_DWORD;
        LT_WORD:     if (len >= 16'd13) k = KIND_WORD;
        LT_QWORD:    if (len >= 16'd43) k = KIND_QWORD;
        default:     k = KIND_NONE;
      endcase
    end
    return k;
  endfunction

endpackage

@@ hw/rtl/arp_capture.sv @@
// field capture for one body byte of the current descriptor
module arp_capture (
  input  logic [7:0]      tag,
  input  logic [15:0]     idx,
  input  logic [7:0]      data,
  input  arp_pkg::held_t  held_in,
  output arp_pkg::held_t  held_out
);
  import arp_pkg::*;

  always_comb begin
    held_out = held_in;
    if (!tag[7]) begin
      case (tag[6:3])
        ST_IRQ: begin
          held_out.mask  = 16'(lane({48'd0, held_in.mask}, idx, 0, 2, data));
          held_out.flags = 8'(lane({56'd0, held_in.flags}, idx, 2, 1, data));
        end
        ST_DMA: begin
          held_out.mask  = 16'(lane({48'd0, held_in.mask}, idx, 0, 1, data));
          held_out.flags = 8'(lane({56'd0, held_in.flags}, idx, 1, 1, data));
        end
        ST_IOPORT: begin
          if (idx == 16'd0) held_out.attr = data[0];
          held_out.base   = lane(held_in.base, idx, 1, 2, data);
          held_out.align  = 8'(lane({56'd0, held_in.align}, idx, 5, 1, data));
          held_out.length = lane(held_in.length, idx, 6, 1, data);
        end
        ST_FIXEDIO: begin
          held_out.base   = lane(held_in.base, idx, 0, 2, data);
          held_out.length = lane(held_in.length, idx, 2, 1, data);
        end
        default: held_out = held_in;
      endcase
    end else begin
      case (tag[6:0])
        LT_EXTIRQ: begin
          held_out.flags     = 8'(lane({56'd0, held_in.flags}, idx, 0, 1, data));
          held_out.irq_count = 8'(lane({56'd0, held_in.irq_count}, idx, 1, 1, data));
          held_out.number    = 32'(lane({32'd0, held_in.number}, idx, 2, 4, data));
        end
        LT_MEM32: begin
          if (idx == 16'd0) held_out.attr = data[0];
          held_out.base   = lane(held_in.base, idx, 1, 4, data);
          held_out.length = lane(held_in.length, idx, 13, 4, data);
        end
        LT_FIXMEM32: begin
          if (idx == 16'd0) held_out.attr = data[0];
          held_out.base   = lane(held_in.base, idx, 1, 4, data);
          held_out.length = lane(held_in.length, idx, 5, 4, data);
        end
        LT_DWORD: begin
          held_out.gran   = lane(held_in.gran, idx, 3, 4, data);
          held_out.base   = lane(held_in.base, idx, 7, 4, data);
          held_out.length = lane(held_in.length, idx, 19, 4, data);
        end
        LT_WORD: begin
          held_out.gran   = lane(held_in.gran, idx, 3, 2, data);
          held_out.base   = lane(held_in.base, idx, 5, 2, data);
          held_out.length = lane(held_in.length, idx, 11, 2, data);
        end
        LT_QWORD: begin
          held_out.gran   = lane(held_in.gran, idx, 3, 8, data);
          held_out.base   = lane(held_in.base, idx, 11, 8, data);
          held_out.length = lane(held_in.length, idx, 35, 8, data);
        end
        default: held_out = held_in;
      endcase
    end
  end

endmodule

@@ hw/rtl/acpi_resource_template_parser_top.sv @@
// top level of the resource template parser
// Takes one template byte per cycle and never stalls while the result register
// is free or being drained; a decoded record or a finish beat appears in the cycle
// after the byte that completes it. Throughput is set by the single result
// register: one byte per cycle whenever the output side keeps up.
module acpi_resource_template_parser_top #(
  parameter int MAX_RECORDS = arp_pkg::MAX_RECORDS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_data_byte,
  input  logic        in_last_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [3:0]  out_kind,
  output logic [63:0] out_base,
  output logic [63:0] out_span_length,
  output logic [63:0] out_granularity,
  output logic [7:0]  out_flags,
  output logic [31:0] out_line_number,
  output logic [15:0] out_line_mask,
  output logic        out_attribute_bit,
  output logic [7:0]  out_alignment,
  output logic        out_finished,
  output logic        out_found_any
);
  import arp_pkg::*;

  phase_t      phase_r, phase_nxt;
  logic [7:0]  tag_r, tag_nxt;
  logic [15:0] blen_r, blen_nxt;
  logic [15:0] bidx_r, bidx_nxt;
  logic [5:0]  cnt_r, cnt_nxt;
  held_t       held_r, held_nxt, held_cap, held_use;

  logic        accept, done, have, complete_req, found;
  logic [7:0]  tag_use;
  logic [15:0] len_use;
  logic [3:0]  kind;
  logic [31:0] low_bit;

  logic        out_valid_r, out_valid_nxt;
  logic [3:0]  kind_r;
  logic [63:0] base_r, len_r, gran_r;
  logic [7:0]  flags_r, align_r;
  logic [31:0] number_r;
  logic [15:0] mask_r;
  logic        attr_r, fin_r, found_r;
  logic [63:0] base_c, len_c, gran_c;
  logic [7:0]  flags_c, align_c;
  logic [31:0] number_c;
  logic [15:0] mask_c;
  logic        attr_c;

  assign in_stall = out_valid_r & out_stall;
  assign accept   = in_valid & ~in_stall;

  arp_capture u_capture (
    .tag      (tag_r),
    .idx      (bidx_r),
    .data     (in_data_byte),
    .held_in  (held_r),
    .held_out (held_cap)
  );

  always_comb begin
    low_bit = 32'd0;
    for (int k = 15; k >= 0; k--)
      if (held_use.mask[k]) low_bit = 32'(k);
  end

  always_comb begin
    phase_nxt    = phase_r;
    tag_nxt      = tag_r;
    blen_nxt     = blen_r;
    bidx_nxt     = bidx_r;
    cnt_nxt      = cnt_r;
    held_nxt     = held_r;
    held_use     = held_r;
    tag_use      = tag_r;
    len_use      = blen_r;
    done         = 1'b0;
    complete_req = 1'b0;
    case (phase_r)
      PH_TAG: begin
        held_nxt = '0;
        held_use = '0;
        tag_nxt  = in_data_byte;
        tag_use  = in_data_byte;
        bidx_nxt = 16'd0;
        if (!in_data_byte[7] && in_data_byte[6:3] == ST_END) begin
          done = 1'b1;
        end else if (in_data_byte[7]) begin
          blen_nxt  = 16'd0;
          phase_nxt = PH_LEN_LO;
          done      = in_last_byte;
        end else begin
          blen_nxt = {13'd0, in_data_byte[2:0]};
          len_use  = {13'd0, in_data_byte[2:0]};
          if (in_data_byte[2:0] == 3'd0) complete_req = 1'b1;
          else phase_nxt = PH_BODY;
          done = in_last_byte;
        end
      end
      PH_LEN_LO: begin
        blen_nxt  = {8'd0, in_data_byte};
        phase_nxt = PH_LEN_HI;
        done      = in_last_byte;
      end
      PH_LEN_HI: begin
        blen_nxt = {in_data_byte, blen_r[7:0]};
        len_use  = {in_data_byte, blen_r[7:0]};
        if ({in_data_byte, blen_r[7:0]} == 16'd0) begin
          phase_nxt    = PH_TAG;
          complete_req = 1'b1;
        end else begin
          phase_nxt = PH_BODY;
        end
        done = in_last_byte;
      end
      PH_BODY: begin
        held_nxt = held_cap;
        held_use = held_cap;
        bidx_nxt = bidx_r + 16'd1;
        if (bidx_r + 16'd1 >= blen_r) begin
          phase_nxt    = PH_TAG;
          complete_req = 1'b1;
        end
        done = in_last_byte;
      end
      PH_DRAIN: begin
        if (in_last_byte) begin
          phase_nxt = PH_TAG;
          cnt_nxt   = 6'd0;
        end
      end
      default: phase_nxt = PH_TAG;
    endcase

    kind = complete_req ? kind_of(tag_use, len_use) : KIND_NONE;
    have = (kind != KIND_NONE);
    if (have) begin
      cnt_nxt = cnt_r + 6'd1;
      if (cnt_nxt >= 6'(MAX_RECORDS)) done = 1'b1;
    end
    found = done && (cnt_nxt != 6'd0);
    if (done) begin
      if (in_last_byte) begin
        phase_nxt = PH_TAG;
        cnt_nxt   = 6'd0;
      end else begin
        phase_nxt = PH_DRAIN;
      end
    end
  end

  always_comb begin
    base_c   = 64'd0;
    len_c    = 64'd0;
    gran_c   = 64'd0;
    flags_c  = 8'd0;
    number_c = 32'd0;
    mask_c   = 16'd0;
    attr_c   = 1'b0;
    align_c  = 8'd0;
    case (kind)
      KIND_IRQ, KIND_DMA: begin
        flags_c  = held_use.flags;
        mask_c   = held_use.mask;
        number_c = low_bit;
      end
      KIND_IOPORT: begin
        base_c  = held_use.base;
        len_c   = held_use.length;
        attr_c  = held_use.attr;
        align_c = held_use.align;
      end
      KIND_FIXEDIO: begin
        base_c = held_use.base;
        len_c  = held_use.length;
      end
      KIND_MEM32: begin
        base_c = held_use.base;
        len_c  = held_use.length;
        attr_c = held_use.attr;
      end
      KIND_EXTIRQ: begin
        flags_c  = held_use.flags;
        attr_c   = held_use.flags[3];
        number_c = (held_use.irq_count != 8'd0 && len_use >= 16'd6) ?
                   held_use.number : 32'd0;
      end
      KIND_WORD, KIND_DWORD, KIND_QWORD: begin
        base_c = held_use.base;
        len_c  = held_use.length;
        gran_c = held_use.gran;
      end
      default: base_c = 64'd0;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r & out_stall;
    if (accept) out_valid_nxt = have | done;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_TAG;
      tag_r       <= 8'd0;
      blen_r      <= 16'd0;
      bidx_r      <= 16'd0;
      cnt_r       <= 6'd0;
      held_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      if (accept) begin
        phase_r <= phase_nxt;
        tag_r   <= tag_nxt;
        blen_r  <= blen_nxt;
        bidx_r  <= bidx_nxt;
        cnt_r   <= cnt_nxt;
        held_r  <= held_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept && (have || done)) begin
      kind_r   <= kind;
      base_r   <= base_c;
      len_r    <= len_c;
      gran_r   <= gran_c;
      flags_r  <= flags_c;
      number_r <= number_c;
      mask_r   <= mask_c;
      attr_r   <= attr_c;
      align_r  <= align_c;
      fin_r    <= done;
      found_r  <= found;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_kind          = kind_r;
  assign out_base          = base_r;
  assign out_span_length   = len_r;
  assign out_granularity   = gran_r;
  assign out_flags         = flags_r;
  assign out_line_number   = number_r;
  assign out_line_mask     = mask_r;
  assign out_attribute_bit = attr_r;
  assign out_alignment     = align_r;
  assign out_finished      = fin_r;
  assign out_found_any     = found_r;

endmodule

@@ hw/rtl/arp_checker.sv @@
// port-level checks for the resource template parser, bound to the top level
`include "acpi_resource_template_parser_top_assert.svh"
module arp_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_stall,
  input logic        out_valid,
  input logic        out_stall,
  input logic [3:0]  out_kind,
  input logic [63:0] out_base,
  input logic        out_finished,
  input logic        out_found_any
);
  import arp_pkg::*;

  // found only reported on the finishing beat
  `ARP_ASSERT_NOW(a_found_needs_finish, out_valid && out_found_any, out_finished)
  // a beat with no record must be a finish beat
  `ARP_ASSERT_NOW(a_none_is_finish, out_valid && out_kind == KIND_NONE, out_finished)
  // input only blocked by a held result
  `ARP_ASSERT_NOW(a_stall_cause, in_stall, out_valid && out_stall)
  // stalled result holds
  `ARP_ASSERT_NEXT(a_hold, out_valid && out_stall,
                   out_valid && $stable(out_kind) && $stable(out_base))

endmodule

bind acpi_resource_template_parser_top arp_checker u_arp_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .in_stall      (in_stall),
  .out_valid     (out_valid),
  .out_stall     (out_stall),
  .out_kind      (out_kind),
  .out_base      (out_base),
  .out_finished  (out_finished),
  .out_found_any (out_found_any)
);

@@ test/tb_acpi_resource_template_parser_top.sv @@
// testbench for the resource template parser: byte stream driver, predictor and record checker
`timescale 1ns / 1ps
module tb_acpi_resource_template_parser_top;
  import arp_pkg::*;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } tbyte_t;

  typedef struct packed {
    logic [3:0]  kind;
    logic [63:0] base;
    logic [63:0] span;
    logic [63:0] gran;
    logic [7:0]  flags;
    logic [31:0] number;
    logic [15:0] mask;
    logic        attr;
    logic [7:0]  align;
    logic        finished;
    logic        found;
  } rec_t;

  logic clk, rst_n;
  logic in_valid, in_stall, in_last_byte;
  logic [7:0] in_data_byte;
  logic out_valid, out_stall;
  logic [3:0] out_kind;
  logic [63:0] out_base, out_span_length, out_granularity;
  logic [7:0] out_flags, out_alignment;
  logic [31:0] out_line_number;
  logic [15:0] out_line_mask;
  logic out_attribute_bit, out_finished, out_found_any;

  acpi_resource_template_parser_top DUT (.*);

  tbyte_t pending_bytes[$];
  rec_t expected_recs[$];
  int errors = 0;
  bit hold_sender = 0;
  int burst_left = 0, gap_left = 0;
  int stall_mode = 0;

  // predictor state
  phase_t ph;
  logic [7:0] tag;
  logic [15:0] blen, bidx;
  logic [5:0] nrec;
  logic [63:0] h_base, h_len, h_gran;
  logic [7:0] h_flags, h_align, h_icnt;
  logic [15:0] h_mask;
  logic [31:0] h_num;
  logic h_attr;

  function automatic logic [63:0] put_byte(logic [63:0] acc, int i, int start, int n,
                                           logic [7:0] b);
    if (i >= start && i - start < n) acc[8*(i-start) +: 8] = acc[8*(i-start) +: 8] | b;
    return acc;
  endfunction

  task automatic clear_fields();
    h_base = 0; h_len = 0; h_gran = 0; h_flags = 0; h_mask = 0;
    h_num = 0; h_attr = 0; h_align = 0; h_icnt = 0;
  endtask

  task automatic gather_field(int i, logic [7:0] b);
    if (!tag[7]) begin
      case (tag[6:3])
        ST_IRQ: begin
          h_mask = 16'(put_byte({48'd0, h_mask}, i, 0, 2, b));
          h_flags = 8'(put_byte({56'd0, h_flags}, i, 2, 1, b));
        end
        ST_DMA: begin
          h_mask = 16'(put_byte({48'd0, h_mask}, i, 0, 1, b));
          h_flags = 8'(put_byte({56'd0, h_flags}, i, 1, 1, b));
        end
        ST_IOPORT: begin
          if (i == 0) h_attr = b[0];
          h_base = put_byte(h_base, i, 1, 2, b);
          h_align = 8'(put_byte({56'd0, h_align}, i, 5, 1, b));
          h_len = put_byte(h_len, i, 6, 1, b);
        end
        ST_FIXEDIO: begin
          h_base = put_byte(h_base, i, 0, 2, b);
          h_len = put_byte(h_len, i, 2, 1, b);
        end
        default: ;
      endcase
    end else begin
      case (tag[6:0])
        LT_EXTIRQ: begin
          h_flags = 8'(put_byte({56'd0, h_flags}, i, 0, 1, b));
          h_icnt = 8'(put_byte({56'd0, h_icnt}, i, 1, 1, b));
          h_num = 32'(put_byte({32'd0, h_num}, i, 2, 4, b));
        end
        LT_MEM32, LT_FIXMEM32: begin
          if (i == 0) h_attr = b[0];
          h_base = put_byte(h_base, i, 1, 4, b);
          h_len = put_byte(h_len, i, (tag[6:0] == LT_MEM32) ? 13 : 5, 4, b);
        end
        LT_DWORD: begin
          h_gran = put_byte(h_gran, i, 3, 4, b);
          h_base = put_byte(h_base, i, 7, 4, b);
          h_len = put_byte(h_len, i, 19, 4, b);
        end
        LT_WORD: begin
          h_gran = put_byte(h_gran, i, 3, 2, b);
          h_base = put_byte(h_base, i, 5, 2, b);
          h_len = put_byte(h_len, i, 11, 2, b);
        end
        LT_QWORD: begin
          h_gran = put_byte(h_gran, i, 3, 8, b);
          h_base = put_byte(h_base, i, 11, 8, b);
          h_len = put_byte(h_len, i, 35, 8, b);
        end
        default: ;
      endcase
    end
  endtask

  function automatic logic [3:0] descriptor_kind();
    logic [3:0] k;
    k = KIND_NONE;
    if (!tag[7]) begin
      case (tag[6:3])
        ST_IRQ:     if (blen >= 2) k = KIND_IRQ;
        ST_DMA:     if (blen >= 2) k = KIND_DMA;
        ST_IOPORT:  if (blen >= 7) k = KIND_IOPORT;
        ST_FIXEDIO: if (blen >= 3) k = KIND_FIXEDIO;
        default: ;
      endcase
    end else begin
      case (tag[6:0])
        LT_EXTIRQ:   if (blen >= 2) k = KIND_EXTIRQ;
        LT_MEM32:    if (blen >= 17) k = KIND_MEM32;
        LT_FIXMEM32: if (blen >= 9) k = KIND_MEM32;
        LT_DWORD:    if (blen >= 23) k = KIND_DWORD;
        LT_WORD:     if (blen >= 13) k = KIND_WORD;
        LT_QWORD:    if (blen >= 43) k = KIND_QWORD;
        default: ;
      endcase
    end
    return k;
  endfunction

  task automatic close_descriptor(output rec_t r, output bit have);
    r = '0;
    r.kind = descriptor_kind();
    have = r.kind != KIND_NONE;
    if (!have) return;
    case (r.kind)
      KIND_IRQ, KIND_DMA: begin
        r.flags = h_flags; r.mask = h_mask;
        for (int k = 15; k >= 0; k--) if (h_mask[k]) r.number = 32'(k);
      end
      KIND_IOPORT: begin
        r.base = h_base; r.span = h_len; r.attr = h_attr; r.align = h_align;
      end
      KIND_FIXEDIO: begin
        r.base = h_base; r.span = h_len;
      end
      KIND_MEM32: begin
        r.base = h_base; r.span = h_len; r.attr = h_attr;
      end
      KIND_EXTIRQ: begin
        r.flags = h_flags; r.attr = h_flags[3];
        r.number = (h_icnt != 0 && blen >= 6) ? h_num : 32'd0;
      end
      default: begin
        r.base = h_base; r.span = h_len; r.gran = h_gran;
      end
    endcase
    nrec = nrec + 6'd1;
  endtask

  task automatic predict_byte(tbyte_t t);
    rec_t r;
    bit done, have, fin_desc;
    logic [7:0] b;
    b = t.data; done = 0; have = 0; fin_desc = 0; r = '0;
    case (ph)
      PH_TAG: begin
        clear_fields();
        tag = b; bidx = 0;
        if (!b[7] && b[6:3] == ST_END) done = 1;
        else if (b[7]) begin
          blen = 0; ph = PH_LEN_LO;
        end else begin
          blen = {13'd0, b[2:0]};
          if (blen == 0) fin_desc = 1;
          else ph = PH_BODY;
        end
      end
      PH_LEN_LO: begin
        blen = {8'd0, b}; ph = PH_LEN_HI;
      end
      PH_LEN_HI: begin
        blen = blen | {b, 8'd0};
        if (blen == 0) begin
          ph = PH_TAG; fin_desc = 1;
        end else ph = PH_BODY;
      end
      PH_BODY: begin
        gather_field(int'(bidx), b);
        bidx = bidx + 16'd1;
        if (bidx >= blen) begin
          ph = PH_TAG; fin_desc = 1;
        end
      end
      default: begin
        if (t.last) begin
          ph = PH_TAG; nrec = 0;
        end
        return;
      end
    endcase
    if (fin_desc) begin
      close_descriptor(r, have);
      if (have && nrec >= DUT.MAX_RECORDS) done = 1;
    end
    if (t.last) done = 1;
    if (!done) begin
      if (have) expected_recs.push_back(r);
      return;
    end
    if (!have) r = '0;
    r.finished = 1;
    r.found = nrec != 0;
    if (t.last) begin
      ph = PH_TAG; nrec = 0;
    end else ph = PH_DRAIN;
    expected_recs.push_back(r);
  endtask

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  // driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 0; in_data_byte <= 0; in_last_byte <= 0;
    end else begin
      if (in_valid && !in_stall) predict_byte({in_data_byte, in_last_byte});
      if (!in_valid || !in_stall) begin
        if (gap_left > 0) gap_left--;
        if (pending_bytes.size() != 0 && !hold_sender && gap_left == 0) begin
          tbyte_t t;
          t = pending_bytes.pop_front();
          in_valid <= 1; in_data_byte <= t.data; in_last_byte <= t.last;
          if (burst_left > 0) burst_left--;
          else begin
            burst_left = $urandom_range(40);
            gap_left = ($urandom_range(3) == 0) ? 0 : $urandom_range(5);
          end
        end else in_valid <= 0;
      end
    end
  end

  // receiver stall pattern and monitor
  always @(posedge clk) begin
    if (!rst_n) out_stall <= 0;
    else begin
      if (out_valid && !out_stall) begin
        rec_t a, e;
        a = {out_kind, out_base, out_span_length, out_granularity, out_flags,
             out_line_number, out_line_mask, out_attribute_bit, out_alignment,
             out_finished, out_found_any};
        if (expected_recs.size() == 0) begin
          $display("%0t unexpected beat %h", $time, a);
          errors++;
        end else begin
          e = expected_recs.pop_front();
          if (a.kind != e.kind || a.base != e.base || a.span != e.span ||
              a.gran != e.gran || a.flags != e.flags || a.number != e.number ||
              a.mask != e.mask || a.attr != e.attr || a.align != e.align ||
              a.finished != e.finished || a.found != e.found) begin
            $display("%0t mismatch expected %h actual %h", $time, e, a);
            errors++;
          end
        end
      end
      if ($urandom_range(200) == 0) stall_mode = $urandom_range(3);
      case (stall_mode)
        0: out_stall <= 0;
        1: out_stall <= ($urandom_range(3) == 0);
        2: out_stall <= ($urandom_range(1) == 0);
        default: out_stall <= ($urandom_range(5) != 0);
      endcase
    end
  end

  task automatic add_byte(logic [7:0] d, bit l = 0);
    pending_bytes.push_back({d, l});
  endtask

  task automatic add_body(int n, bit end_last);
    for (int i = 0; i < n; i++) add_byte($urandom, end_last && i == n - 1);
  endtask

  task automatic add_descriptor(bit end_last);
    int sel, n;
    logic [6:0] lt;
    sel = $urandom_range(11);
    if (sel < 5) begin
      logic [3:0] st;
      case (sel)
        0: st = ST_IRQ;
        1: st = ST_DMA;
        2: st = ST_IOPORT;
        3: st = ST_FIXEDIO;
        default: st = 4'($urandom_range(14));
      endcase
      n = $urandom_range(7);
      add_byte({1'b0, st, 3'(n)}, end_last && n == 0);
      add_body(n, end_last);
    end else begin
      case (sel)
        5: begin lt = LT_MEM32; n = 17; end
        6: begin lt = LT_FIXMEM32; n = 9; end
        7: begin lt = LT_DWORD; n = 23; end
        8: begin lt = LT_WORD; n = 13; end
        9: begin lt = LT_EXTIRQ; n = $urandom_range(2, 10); end
        10: begin lt = LT_QWORD; n = 43; end
        default: begin lt = $urandom; n = $urandom_range(6); end
      endcase
      if ($urandom_range(5) == 0) n = $urandom_range(n + 3);
      add_byte({1'b1, lt});
      add_byte(n[7:0]);
      add_byte(n[15:8], end_last && n == 0);
      add_body(n, end_last);
    end
  endtask

  task automatic add_template();
    int cnt, mode;
    cnt = $urandom_range(8);
    mode = $urandom_range(9);
    for (int i = 0; i < cnt; i++) add_descriptor(mode == 0 && i == cnt - 1);
    if (mode == 0 && cnt != 0) return;
    if (mode == 1) begin
      add_byte($urandom, 1);
      return;
    end
    add_byte({1'b0, ST_END, 3'($urandom_range(1))}, mode > 5);
    if (mode <= 5) begin
      repeat ($urandom_range(3)) add_byte($urandom);
      add_byte($urandom, 1);
    end
  endtask

  initial begin
    rst_n = 0;
    ph = PH_TAG; tag = 0; blen = 0; bidx = 0; nrec = 0;
    clear_fields();
    repeat (10) @(posedge clk);
    rst_n <= 1;
    // directed: irq, dma, ioport, fixedio, empty irq, extirq, unknown large item, end tag with trailing bytes
    add_byte({1'b0, ST_IRQ, 3'd3}); add_byte(8'h00); add_byte(8'h80); add_byte(8'hFF);
    add_byte({1'b0, ST_DMA, 3'd2}); add_byte(8'h10); add_byte(8'h00);
    add_byte({1'b0, ST_IOPORT, 3'd7}); add_body(7, 0);
    add_byte({1'b0, ST_FIXEDIO, 3'd3}); add_byte(8'hFF); add_byte(8'hFF); add_byte(8'hFF);
    add_byte({1'b0, ST_IRQ, 3'd0});
    add_byte({1'b1, LT_EXTIRQ}); add_byte(8'd6); add_byte(8'd0); add_body(6, 0);
    add_byte({1'b1, 7'h7F}); add_byte(8'd0); add_byte(8'd0);
    add_byte({1'b0, ST_END, 3'd1}); add_byte(8'hAA); add_byte(8'h55, 1);
    // truncation inside a length, then empty large body on the last byte
    add_byte({1'b1, LT_QWORD}); add_byte(8'd43, 1);
    add_byte({1'b1, LT_WORD}); add_byte(8'd0); add_byte(8'd0, 1);
    // record cap
    repeat (DUT.MAX_RECORDS) begin
      add_byte({1'b0, ST_IRQ, 3'd2}); add_byte(8'h00); add_byte(8'h00);
    end
    add_byte(8'h00); add_byte(8'h00, 1);
    add_byte({1'b0, ST_END, 3'd0}, 1);
    while (pending_bytes.size() > 0) @(posedge clk);
    hold_sender = 1;
    while (expected_recs.size() > 0 || in_valid) @(posedge clk);
    hold_sender = 0;
    while (pending_bytes.size() < 1700) begin
      if ($urandom_range(15) == 0) repeat ($urandom_range(20)) add_byte($urandom, $urandom_range(9) == 0);
      else add_template();
    end
    add_byte({1'b0, ST_END, 3'd0}, 1);
    while (pending_bytes.size() > 0 || in_valid) @(posedge clk);
    while (expected_recs.size() > 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (errors == 0)
      $display("== PASS ==");
    else
      $display("== FAIL ==");
    $finish;
  end

  initial begin
    #5000000;
    $display("== FAIL ==");
    $finish;
  end
endmodule
